// ===== rtl/dag_pkg.sv =====
// Shared types, widths and helpers for the distance attenuated gain block.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
package dag_pkg;

    localparam int POSITION_BITS  = 24;
    localparam int GAIN_FRAC_BITS = 15;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
    localparam int ROOT_BITS      = POSITION_BITS + 1;
    localparam int RAD_BITS       = 2 * ROOT_BITS;
    localparam int SQ_BITS        = 2 * POSITION_BITS;
    localparam int CFG_DATA_BITS  = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;
    localparam int CFG_IDX_BITS   = 3;
    localparam int TAG_BITS       = 16;
    localparam int STATE_BITS     = 2;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
    localparam logic [STATE_BITS-1:0] STATE_PLAYING = 2'd1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MASTER_VOLUME,
        CFG_LISTENER_X,
        CFG_LISTENER_Y,
        CFG_LISTENER_Z,
        CFG_MAX_DISTANCE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ATT_ONE,
        ATT_ZERO,
        ATT_DIV
    } t_att_mode;

    typedef struct packed {
        logic [TAG_BITS-1:0]             source_tag;
        logic [STATE_BITS-1:0]           source_state;
        logic [GAIN_BITS-1:0]            source_volume;
        logic signed [POSITION_BITS-1:0] source_x;
        logic signed [POSITION_BITS-1:0] source_y;
        logic signed [POSITION_BITS-1:0] source_z;
    } t_in;

    typedef struct packed {
        logic [TAG_BITS-1:0]  result_tag;
        logic [GAIN_BITS-1:0] gain;
    } t_out;

    // Data that rides alongside the arithmetic through the long units.
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic                 playing;
        logic [GAIN_BITS-1:0] vol;
        t_att_mode            mode;
    } t_side;

    function automatic logic [POSITION_BITS-1:0] abs_diff(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b
    );
        logic [POSITION_BITS:0] d;
        logic [POSITION_BITS:0] nd;
        d  = {a[POSITION_BITS-1], a} - {b[POSITION_BITS-1], b};
        nd = -d;
        return d[POSITION_BITS] ? nd[POSITION_BITS-1:0] : d[POSITION_BITS-1:0];
    endfunction

    function automatic logic [GAIN_BITS-1:0] clamp_gain(input logic [GAIN_BITS-1:0] v);
        return (v > GAIN_ONE) ? GAIN_ONE : v;
    endfunction

endpackage

// ===== rtl/dag_sqrt.sv =====
// Pipelined floor square root, one root bit per stage.
// Depends on dag_pkg.
`timescale 1ns / 1ps
module dag_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [dag_pkg::RAD_BITS-1:0]  i_rad,
    input  dag_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [dag_pkg::ROOT_BITS-1:0] o_root,
    output dag_pkg::t_side                o_side
);
    import dag_pkg::*;

    localparam int REM_W = ROOT_BITS + 3;

    logic                 r_v    [0:ROOT_BITS];
    logic [RAD_BITS-1:0]  r_n    [0:ROOT_BITS];
    logic [REM_W-1:0]     r_rem  [0:ROOT_BITS];
    logic [ROOT_BITS-1:0] r_q    [0:ROOT_BITS];
    t_side                r_side [0:ROOT_BITS];

    always_comb begin
        r_v[0]    = i_valid;
        r_n[0]    = i_rad;
        r_rem[0]  = '0;
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [REM_W-1:0] n_rem_sh;
        logic [REM_W-1:0] n_trial;
        always_comb begin
            // Bring down the next two radicand bits, try appending a one.
            n_rem_sh = {r_rem[k][REM_W-3:0], r_n[k][RAD_BITS-1:RAD_BITS-2]};
            n_trial  = {2'b00, r_q[k][ROOT_BITS-2:0], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_n[k+1]    <= {r_n[k][RAD_BITS-3:0], 2'b00};
                r_side[k+1] <= r_side[k];
                if (n_rem_sh >= n_trial) begin
                    r_rem[k+1] <= n_rem_sh - n_trial;
                    r_q[k+1]   <= {r_q[k][ROOT_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_rem_sh;
                    r_q[k+1]   <= {r_q[k][ROOT_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[ROOT_BITS];
    assign o_root  = r_q[ROOT_BITS];
    assign o_side  = r_side[ROOT_BITS];
endmodule

// ===== rtl/dag_div.sv =====
// Pipelined restoring divider giving the attenuation fraction, one bit per stage.
// Depends on dag_pkg.
`timescale 1ns / 1ps
module dag_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [dag_pkg::POSITION_BITS-1:0]  i_num,
    input  logic [dag_pkg::POSITION_BITS-1:0]  i_den,
    input  dag_pkg::t_side                     i_side,
    output logic                               o_valid,
    output logic [dag_pkg::GAIN_FRAC_BITS-1:0] o_quo,
    output dag_pkg::t_side                     o_side
);
    import dag_pkg::*;

    localparam int F = GAIN_FRAC_BITS;

    logic                   r_v    [0:F];
    logic [POSITION_BITS:0] r_rem  [0:F];
    logic [F-1:0]           r_q    [0:F];
    t_side                  r_side [0:F];

    always_comb begin
        r_v[0]    = i_valid;
        r_rem[0]  = {1'b0, i_num};
        r_q[0]    = '0;
        r_side[0] = i_side;
    end

    for (genvar k = 0; k < F; k++) begin : g_stage
        logic [POSITION_BITS:0] n_sh;
        assign n_sh = {r_rem[k][POSITION_BITS-1:0], 1'b0};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                if (n_sh >= {1'b0, i_den}) begin
                    r_rem[k+1] <= n_sh - {1'b0, i_den};
                    r_q[k+1]   <= {r_q[k][F-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= n_sh;
                    r_q[k+1]   <= {r_q[k][F-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[F];
    assign o_quo   = r_q[F];
    assign o_side  = r_side[F];
endmodule

// ===== rtl/distance_attenuated_gain.sv =====
// Top level of the distance attenuated gain block: config registers and pipeline.
// Depends on dag_pkg, dag_sqrt and dag_div.
`timescale 1ns / 1ps
// One beat in, one beat out per source, in order. The block takes a new beat
// every cycle unless the input is stalled by a held output. A beat passes through
// the offset, square and sum registers, the square root pipeline, the setup
// register, the divider pipeline, and the final gain multiply into the output
// register. The whole pipeline advances together; it holds only when a result
// sits in the output register and the sink stalls, so bubbles fill while the sink
// is idle. Config writes are always taken and must only be issued while no beat
// is in flight.
module distance_attenuated_gain (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  dag_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output dag_pkg::t_out                    o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dag_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [dag_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import dag_pkg::*;

    localparam int F = GAIN_FRAC_BITS;

    // Config registers.
    logic [GAIN_BITS-1:0]     r_master;
    logic [POSITION_BITS-1:0] r_lx, r_ly, r_lz, r_maxd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= GAIN_ONE;
            r_lx     <= '0;
            r_ly     <= '0;
            r_lz     <= '0;
            r_maxd   <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MASTER_VOLUME: r_master <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LISTENER_X:    r_lx     <= i_cfg_data[POSITION_BITS-1:0];
                CFG_LISTENER_Y:    r_ly     <= i_cfg_data[POSITION_BITS-1:0];
                CFG_LISTENER_Z:    r_lz     <= i_cfg_data[POSITION_BITS-1:0];
                CFG_MAX_DISTANCE:  r_maxd   <= i_cfg_data[POSITION_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output beat is held by the sink.
    logic w_en;
    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    // Stage 1: absolute offsets and the volume product.
    logic                     r1_v;
    logic [POSITION_BITS-1:0] r1_dx, r1_dy, r1_dz;
    t_side                    r1_side;
    t_side                    n1_side;
    logic [2*GAIN_BITS-1:0]   n1_vp;

    always_comb begin
        n1_vp           = clamp_gain(r_master) * clamp_gain(i_in.source_volume);
        n1_side.tag     = i_in.source_tag;
        n1_side.playing = (i_in.source_state == STATE_PLAYING);
        n1_side.vol     = n1_vp[F+GAIN_BITS-1:F];
        n1_side.mode    = ATT_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
        end
        if (w_en) begin
            r1_dx   <= abs_diff(i_in.source_x, r_lx);
            r1_dy   <= abs_diff(i_in.source_y, r_ly);
            r1_dz   <= abs_diff(i_in.source_z, r_lz);
            r1_side <= n1_side;
        end
    end

    // Stage 2: squares.
    logic               r2_v;
    logic [SQ_BITS-1:0] r2_sx, r2_sy, r2_sz;
    t_side              r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            r2_sx   <= r1_dx * r1_dx;
            r2_sy   <= r1_dy * r1_dy;
            r2_sz   <= r1_dz * r1_dz;
            r2_side <= r1_side;
        end
    end

    // Stage 3: squared distance; the radicand has room for the sum of three.
    logic                r3_v;
    logic [RAD_BITS-1:0] r3_rad;
    t_side               r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
        if (w_en) begin
            r3_rad  <= RAD_BITS'(r2_sx) + RAD_BITS'(r2_sy) + RAD_BITS'(r2_sz);
            r3_side <= r2_side;
        end
    end

    logic                 w_sq_v;
    logic [ROOT_BITS-1:0] w_root;
    t_side                w_sq_side;

    dag_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_rad   (r3_rad),
        .i_side  (r3_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // Setup stage: pick the attenuation case and the numerator.
    logic                     r4_v;
    logic [POSITION_BITS-1:0] r4_num;
    t_side                    r4_side;
    t_side                    n4_side;

    always_comb begin
        n4_side = w_sq_side;
        if (r_maxd == '0 || w_root == '0) begin
            n4_side.mode = ATT_ONE;
        end else if (w_root >= {1'b0, r_maxd}) begin
            n4_side.mode = ATT_ZERO;
        end else begin
            n4_side.mode = ATT_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= w_sq_v;
        end
        if (w_en) begin
            r4_side <= n4_side;
            r4_num  <= r_maxd - w_root[POSITION_BITS-1:0];
        end
    end

    logic         w_dv_v;
    logic [F-1:0] w_quo;
    t_side        w_dv_side;

    dag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r_maxd),
        .i_side  (r4_side),
        .o_valid (w_dv_v),
        .o_quo   (w_quo),
        .o_side  (w_dv_side)
    );

    // Final stage: scale the volume product by the attenuation.
    logic [GAIN_BITS-1:0]   n_att;
    logic [2*GAIN_BITS-1:0] n_prod;
    t_out                   n_out;

    always_comb begin
        case (w_dv_side.mode)
            ATT_ONE:  n_att = GAIN_ONE;
            ATT_ZERO: n_att = '0;
            ATT_DIV:  n_att = {1'b0, w_quo};
            default:  n_att = '0;
        endcase
        n_prod           = w_dv_side.vol * n_att;
        n_out.result_tag = w_dv_side.tag;
        n_out.gain       = w_dv_side.playing ? n_prod[F+GAIN_BITS-1:F] : '0;
    end

    logic r_out_v;
    t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_dv_v;
        end
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // A gain never exceeds unity.
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.gain <= GAIN_ONE))
        else $error("gain above unity");

    // Input is held off only while a result waits on the sink.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // A held result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");
endmodule
